// ===== rtl/core/shm_pkg.sv =====
// ----------------------------------------------------------------------------
// shm_pkg: shared types and constants of the sensor health monitor
// Sensor and channel counts, register indexes and the command bundle.
// ----------------------------------------------------------------------------
package shm_pkg;

  localparam int NUM_SENSORS = 2;
  localparam int CHANNELS    = 8;
  localparam int SENS_W      = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

  // configuration port
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CHANNELS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_INTERVAL  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_UPDATE_GAP  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_MULTIPLIER = 4'd3;

  localparam logic [19:0] RATE_MAX = 20'hFFFFF;

  // input function codes
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_POLL   = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic              sample_wr;  // store a sample beat
    logic              latch_now;  // capture the poll time
    logic              check_en;   // run the check of sensor sel
    logic [SENS_W-1:0] sel;        // sensor under check
  } shm_cmd_t;

endpackage

// ===== rtl/core/shm_ctrl.sv =====
// ----------------------------------------------------------------------------
// shm_ctrl: sequencer of the sensor health monitor
// Takes input beats, walks the sensors on a poll and hands out results.
// ----------------------------------------------------------------------------
module shm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              func,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output shm_pkg::shm_cmd_t cmd
);
  import shm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_OUT   = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [SENS_W-1:0] cnt;
  logic [SENS_W-1:0] cnt_next;
  logic              last;
  logic              in_acc;
  logic              out_acc;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign in_acc    = in_valid & in_ready;
  assign out_acc   = out_valid & out_ready;
  assign last      = (cnt == SENS_W'(NUM_SENSORS - 1));

  // commands
  always_comb begin
    cmd.sample_wr = in_acc & (func == FUNC_SAMPLE);
    cmd.latch_now = in_acc & (func == FUNC_POLL);
    cmd.check_en  = (state == ST_CHECK);
    cmd.sel       = cnt;
  end

  // next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && func == FUNC_POLL) begin
          state_next = ST_CHECK;
          cnt_next   = '0;
        end
      end
      ST_CHECK: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_acc) begin
          if (last) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_CHECK;
            cnt_next   = cnt + 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

`ifndef SYNTHESIS
  a_poll_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.latch_now |=> (cmd.check_en && cmd.sel == '0))
    else $error("poll did not start a check of the first sensor");

  a_check_then_result: assert property (@(posedge clk) disable iff (rst)
    cmd.check_en |=> (out_valid && $stable(cmd.sel)))
    else $error("check not followed by its result");

  a_last_result_frees_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> in_ready)
    else $error("input not freed after last result");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && (out_valid || cmd.check_en)))
    else $error("input taken while a poll is running");
`endif

endmodule

// ===== rtl/core/shm_dp.sv =====
// ----------------------------------------------------------------------------
// shm_dp: datapath of the sensor health monitor
// Per-sensor stores, configuration registers, check logic and result register.
// ----------------------------------------------------------------------------
module shm_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  shm_pkg::shm_cmd_t                cmd,
  input  logic                             cfg_valid,
  input  logic [shm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [shm_pkg::CFG_DAT_W-1:0]    cfg_data,
  input  logic [2:0]                       sensor_index,
  input  logic [31:0]                      now_ms,
  input  logic signed [31:0]               chan_in [8],
  output logic [2:0]                       which_sensor,
  output logic                             checked,
  output logic                             healthy,
  output logic [19:0]                      rate_hz,
  output logic                             last_of_run
);
  import shm_pkg::*;

  // configuration
  logic [3:0]  active_channels;
  logic [15:0] check_interval_ms;
  logic [15:0] max_update_gap_ms;
  logic [4:0]  rate_multiplier;

  // per-sensor state
  logic [31:0] sample_row [NUM_SENSORS][CHANNELS];
  logic [31:0] prev_row   [NUM_SENSORS][CHANNELS];
  logic [31:0] last_sample_time [NUM_SENSORS];
  logic [31:0] last_check_time  [NUM_SENSORS];
  logic [15:0] sample_count     [NUM_SENSORS];
  logic        good_flag        [NUM_SENSORS];

  logic [31:0] now_q;

  // check terms
  logic [SENS_W-1:0]   wr_sel;
  logic                wr_ok;
  logic [31:0]         since_chk;
  logic [31:0]         age;
  logic                due;
  logic                stale;
  logic [CHANNELS-1:0] mask;
  logic [CHANNELS-1:0] diff;
  logic                changed;
  logic [20:0]         prod;
  logic [19:0]         rate_sat;

  assign wr_sel = sensor_index[SENS_W-1:0];
  assign wr_ok  = ({1'b0, sensor_index} < 4'(NUM_SENSORS));

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      active_channels   <= 4'd8;
      check_interval_ms <= 16'd100;
      max_update_gap_ms <= 16'd16;
      rate_multiplier   <= 5'd10;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ACTIVE_CHANNELS: active_channels   <= cfg_data[3:0];
        CFG_CHECK_INTERVAL:  check_interval_ms <= cfg_data;
        CFG_MAX_UPDATE_GAP:  max_update_gap_ms <= cfg_data;
        CFG_RATE_MULTIPLIER: rate_multiplier   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // check of the selected sensor
  assign since_chk = now_q - last_check_time[cmd.sel];
  assign age       = now_q - last_sample_time[cmd.sel];
  assign due       = (since_chk >= {16'd0, check_interval_ms});
  assign stale     = (age > {16'd0, max_update_gap_ms});

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      mask[c] = (4'(c) < active_channels);
      diff[c] = mask[c] & (sample_row[cmd.sel][c] != prev_row[cmd.sel][c]);
    end
  end

  assign changed  = |diff;
  assign prod     = 21'(sample_count[cmd.sel]) * 21'(rate_multiplier);
  assign rate_sat = prod[20] ? RATE_MAX : prod[19:0];

  // poll time
  always_ff @(posedge clk) begin
    if (cmd.latch_now) begin
      now_q <= now_ms;
    end
  end

  // sensor state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SENSORS; s++) begin
        for (int c = 0; c < CHANNELS; c++) begin
          sample_row[s][c] <= '0;
          prev_row[s][c]   <= '0;
        end
        last_sample_time[s] <= '0;
        last_check_time[s]  <= '0;
        sample_count[s]     <= '0;
        good_flag[s]        <= 1'b0;
      end
    end else if (cmd.sample_wr) begin
      if (wr_ok) begin
        for (int c = 0; c < CHANNELS; c++) begin
          sample_row[wr_sel][c] <= chan_in[c];
        end
        last_sample_time[wr_sel] <= now_ms;
        if (sample_count[wr_sel] != 16'hFFFF) begin
          sample_count[wr_sel] <= sample_count[wr_sel] + 16'd1;
        end
      end
    end else if (cmd.check_en && due) begin
      sample_count[cmd.sel]    <= '0;
      last_check_time[cmd.sel] <= now_q;
      if (stale) begin
        good_flag[cmd.sel] <= 1'b0;
      end else begin
        good_flag[cmd.sel] <= changed;
        for (int c = 0; c < CHANNELS; c++) begin
          if (mask[c]) begin
            prev_row[cmd.sel][c] <= sample_row[cmd.sel][c];
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.check_en) begin
      which_sensor <= 3'(cmd.sel);
      checked      <= due;
      healthy      <= due ? (!stale && changed) : good_flag[cmd.sel];
      rate_hz      <= due ? rate_sat : '0;
      last_of_run  <= (cmd.sel == SENS_W'(NUM_SENSORS - 1));
    end
  end

endmodule

// ===== rtl/core/sensor_health_monitor.sv =====
// ----------------------------------------------------------------------------
// sensor_health_monitor: top level
// Sample beat: stored, no result. Poll beat: one result per sensor, from a check
// state, then the result register, held while the output stalls; input is held
// off until the last result goes. Reset clears all but poll time and results.
// ----------------------------------------------------------------------------
module sensor_health_monitor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [shm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [shm_pkg::CFG_DAT_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          func,
  input  logic [2:0]                    sensor_index,
  input  logic [31:0]                   now_ms,
  input  logic signed [31:0]            chan0,
  input  logic signed [31:0]            chan1,
  input  logic signed [31:0]            chan2,
  input  logic signed [31:0]            chan3,
  input  logic signed [31:0]            chan4,
  input  logic signed [31:0]            chan5,
  input  logic signed [31:0]            chan6,
  input  logic signed [31:0]            chan7,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    which_sensor,
  output logic                          checked,
  output logic                          healthy,
  output logic [19:0]                   rate_hz,
  output logic                          last_of_run
);
  import shm_pkg::*;

  shm_cmd_t           cmd;
  logic signed [31:0] chan_in [8];

  // registers are always writable
  assign cfg_ready = 1'b1;

  assign chan_in[0] = chan0;
  assign chan_in[1] = chan1;
  assign chan_in[2] = chan2;
  assign chan_in[3] = chan3;
  assign chan_in[4] = chan4;
  assign chan_in[5] = chan5;
  assign chan_in[6] = chan6;
  assign chan_in[7] = chan7;

  shm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .func      (func),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  shm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sensor_index (sensor_index),
    .now_ms       (now_ms),
    .chan_in      (chan_in),
    .which_sensor (which_sensor),
    .checked      (checked),
    .healthy      (healthy),
    .rate_hz      (rate_hz),
    .last_of_run  (last_of_run)
  );

endmodule
